>>> src/slr_pkg.sv
// Shared types and constants for the shuffled Lehmer random generator.
package slr_pkg;

	// Park-Miller minimal standard generator constants.
	localparam logic [14:0] LCG_MULT = 15'd16807;
	localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
	// Largest deviate allowed below one: floor(2^32 * (1 - 1.2e-7)).
	localparam logic [31:0] DEV_CAP  = 32'd4294966780;

	typedef struct packed {
		logic        kind;
		logic [30:0] seed;
	} req_t;

	typedef struct packed {
		logic [30:0] raw_value;
		logic [31:0] deviate;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_seed;
		logic mul;
		logic seed_fold;
		logic draw_read;
		logic draw_done;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_zero;
		logic cnt_zero;
		logic out_free;
	} stat_t;

endpackage

>>> src/slr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/slr_datapath.sv
// Datapath: generator step, shuffle table, slot select and deviate scaling.
module slr_datapath #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  slr_pkg::req_t req,
	input  slr_pkg::cmd_t cmd,
	output slr_pkg::stat_t stat,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output slr_pkg::rsp_t rsp
);
	import slr_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 8);
	localparam longint SLOT_DIV = 64'd1 + (64'd2147483646 / TABLE_ENTRIES);

	logic [30:0]      gen_q;
	logic [30:0]      last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [45:0]      prod_s1;
	logic             out_valid_q;
	rsp_t             rsp_q;

	logic [30:0]              seed_val;
	logic [31:0]              fold_sum;
	logic [30:0]              fold_val;
	logic [TABLE_ENTRIES-2:0] therm;
	logic [IDX_W-1:0]         slot;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [30:0]              ram_rdata;
	logic [31:0]              dbl;
	logic [32:0]              dev_full;
	logic [31:0]              dev_val;

	// A zero seed, or one equal to the modulus, starts from 1.
	always_comb begin
		seed_val = 31'd1;
		if (req.kind && (req.seed != '0) && (req.seed != LCG_MOD)) begin
			seed_val = req.seed;
		end
	end

	// Reduction mod 2^31-1: fold the high bits onto the low bits, then one subtract.
	always_comb begin
		fold_sum = {1'b0, prod_s1[30:0]} + {17'd0, prod_s1[45:31]};
		if (fold_sum >= {1'b0, LCG_MOD}) begin
			fold_val = 31'(fold_sum - {1'b0, LCG_MOD});
		end else begin
			fold_val = fold_sum[30:0];
		end
	end

	// Slot index: count of constant thresholds that the last output reaches.
	for (genvar k = 1; k < TABLE_ENTRIES; k++) begin : g_thr
		assign therm[k-1] = ({1'b0, last_q} >= 32'(k * SLOT_DIV));
	end
	assign slot = IDX_W'($countones(therm));

	// floor(v * 2^32 / (2^31-1)) equals 2v plus one when 2v reaches the modulus.
	always_comb begin
		dbl      = {ram_rdata, 1'b0};
		dev_full = {1'b0, dbl} + {32'd0, (dbl >= {1'b0, LCG_MOD})};
		if (dev_full > {1'b0, DEV_CAP}) begin
			dev_val = DEV_CAP;
		end else begin
			dev_val = dev_full[31:0];
		end
	end

	assign ram_we    = (cmd.seed_fold && (cnt_q < CNT_W'(TABLE_ENTRIES))) || cmd.draw_done;
	assign ram_waddr = cmd.seed_fold ? cnt_q[IDX_W-1:0] : slot;

	slr_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(fold_val),
		.re   (cmd.draw_read),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= gen_q * LCG_MULT;
		end
		if (cmd.draw_done) begin
			rsp_q.raw_value <= ram_rdata;
			rsp_q.deviate   <= dev_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= '0;
			last_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				gen_q <= seed_val;
				cnt_q <= CNT_W'(TABLE_ENTRIES + 7);
			end else if (cmd.seed_fold || cmd.draw_done) begin
				gen_q <= fold_val;
			end
			if (cmd.seed_fold) begin
				if (cnt_q == '0) begin
					last_q <= fold_val;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.draw_done) begin
				last_q      <= ram_rdata;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.last_zero = (last_q == '0);
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid      = out_valid_q;
	assign rsp            = rsp_q;

endmodule

>>> src/slr_ctrl.sv
// Controller: sequences seeding and draws over the datapath.
module slr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_kind,
	output logic           req_stall,
	input  slr_pkg::stat_t stat,
	output slr_pkg::cmd_t  cmd
);
	import slr_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SEED_MUL  = 3'd1;
	localparam logic [2:0] ST_SEED_FOLD = 3'd2;
	localparam logic [2:0] ST_DRAW_MUL  = 3'd3;
	localparam logic [2:0] ST_DRAW_FOLD = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       need_seed;

	assign need_seed = req_kind || stat.last_zero;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (need_seed) begin
						cmd.load_seed = 1'b1;
						state_nx      = ST_SEED_MUL;
					end else begin
						state_nx = ST_DRAW_MUL;
					end
				end
			end
			ST_SEED_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = ST_SEED_FOLD;
			end
			ST_SEED_FOLD: begin
				cmd.seed_fold = 1'b1;
				state_nx      = stat.cnt_zero ? ST_DRAW_MUL : ST_SEED_MUL;
			end
			ST_DRAW_MUL: begin
				cmd.mul       = 1'b1;
				cmd.draw_read = 1'b1;
				state_nx      = ST_DRAW_FOLD;
			end
			ST_DRAW_FOLD: begin
				if (stat.out_free) begin
					cmd.draw_done = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

>>> src/shuffled_lehmer_random.sv
// Top level of the shuffled minimal-standard random generator.
//
//  channel | signals                   | transfer moves
//  --------+---------------------------+-----------------------------------
//  req     | req_valid, req_stall, req | one draw request (kind, seed)
//  rsp     | rsp_valid, rsp_stall, rsp | one result (raw_value, deviate)
//
// A plain draw runs from the request transfer until the next request can be
// taken through acceptance in the idle state, the multiply by 16807 together
// with the registered table read, and the fold mod 2^31-1. A reseed, or a
// draw while unseeded, adds a seeding run of TABLE_ENTRIES+8 generator steps,
// each a multiply state and a fold state. Reset leaves the generator
// unseeded; the table contents are undefined until the first seeding writes
// them. A finished result waits in the output register while the next
// request is taken; a draw only stalls in its fold state if that register
// is still full and stalled.
//
// The generator is Park-Miller with multiplier 16807 and modulus 2^31-1.
// Each draw picks a shuffle slot from the previous output, returns the
// slot's content and refills the slot with the freshly stepped value. The
// deviate is the result scaled to an unsigned Q0.32 fraction and capped
// just below one.
module shuffled_lehmer_random #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  slr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output slr_pkg::rsp_t rsp
);
	import slr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The controller only sequences; all arithmetic and storage sit in the datapath.
	slr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_kind (req.kind),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	slr_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

>>> sim/testbench.sv
// Testbench for the shuffled Lehmer random generator: queued requests, scoreboard.
`timescale 1ns / 100ps

module testbench;
	import slr_pkg::*;

	localparam int TABLE_ENTRIES = 32;
	// Divisor that maps the previous output onto a shuffle slot.
	localparam longint unsigned SLOT_DIV = 1 + (longint'(LCG_MOD) - 1) / TABLE_ENTRIES;
	localparam int CYCLE_LIMIT = 500000;
	// Quiet cycles after the last result, well past the block's own latency.
	localparam int DRAIN_CYCLES = 100;

	// Request kinds carried in the kind field.
	localparam logic REQ_DRAW   = 1'b0;
	localparam logic REQ_RESEED = 1'b1;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_LIGHT
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	shuffled_lehmer_random #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Requests waiting to be driven, and the results still owed by the block.
	req_t draw_requests[$];
	rsp_t owed_values[$];

	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_reseeds = 0;
	int n_seedings = 0;
	int cap_hits = 0;
	int mismatches = 0;
	int cycle_count = 0;
	logic [TABLE_ENTRIES-1:0] slots_hit = '0;

	// Our own copy of the generator state. The table is only read after a
	// seeding run has filled every slot, so it needs no reset value.
	logic [30:0] gen_state = '0;
	logic [30:0] last_out = '0;
	logic [30:0] shuffle[TABLE_ENTRIES];

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// One Park-Miller step: value * 16807 mod (2^31 - 1).
	function automatic logic [30:0] park_miller_step(input logic [30:0] v);
		longint unsigned p;
		p = v;
		p = p * LCG_MULT;
		p = p % LCG_MOD;
		return p[30:0];
	endfunction

	// Seeding run: warm up the generator and fill the table from the top slot down.
	task automatic seed_table(input logic [30:0] s);
		logic [30:0] v;
		v = s % LCG_MOD;
		if (v == 0) begin
			v = 31'd1;
		end
		for (int n = TABLE_ENTRIES + 7; n >= 0; n--) begin
			v = park_miller_step(v);
			if (n < TABLE_ENTRIES) begin
				shuffle[n] = v;
			end
		end
		gen_state = v;
		last_out = shuffle[0];
		n_seedings++;
	endtask

	// Predict the result of one accepted request and advance our state.
	task automatic lehmer_draw(input req_t r, output rsp_t res);
		int slot;
		logic [30:0] value;
		longint unsigned scaled;
		if (r.kind == REQ_RESEED) begin
			seed_table(r.seed);
			n_reseeds++;
		end else if (last_out == 0) begin
			seed_table(31'd1);
		end
		gen_state = park_miller_step(gen_state);
		slot = int'(last_out / SLOT_DIV);
		if (slot >= TABLE_ENTRIES) begin
			slot = TABLE_ENTRIES - 1;
		end
		value = shuffle[slot];
		shuffle[slot] = gen_state;
		last_out = value;
		slots_hit[slot] = 1'b1;
		scaled = {1'b0, value, 32'd0};
		scaled = scaled / LCG_MOD;
		if (scaled > DEV_CAP) begin
			scaled = DEV_CAP;
			cap_hits++;
		end
		res.raw_value = value;
		res.deviate = scaled[31:0];
	endtask

	task automatic queue_request(input logic kind, input logic [30:0] seed);
		req_t r;
		r.kind = kind;
		r.seed = seed;
		draw_requests.push_back(r);
		n_queued++;
	endtask

	// Random request: mostly plain draws so the shuffle runs long, with the
	// occasional reseed. Seeds cover all 31 bits plus both zero-like values.
	task automatic queue_random_request();
		logic kind;
		logic [30:0] seed;
		int pick;
		kind = ($urandom_range(0, 15) == 0) ? REQ_RESEED : REQ_DRAW;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			seed = '0;
		end else if (pick == 1) begin
			seed = LCG_MOD;
		end else begin
			seed = 31'($urandom);
		end
		queue_request(kind, seed);
	endtask

	// Hold the sender back until every request has been taken and every
	// result has come back.
	task automatic wait_for_idle();
		while (n_accepted != n_queued || owed_values.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Monitor. Everything is sampled at the rising edge, where a transfer
	// happens on valid high and stall low. The result check comes first: a
	// request taken at this edge cannot have produced a result yet.
	logic req_fire = 1'b0;

	always @(posedge clk) begin : monitor
		rsp_t want;
		cycle_count <= cycle_count + 1;
		req_fire <= arst_n && req_valid && !req_stall;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_values.size() == 0) begin
					report_mismatch("result transfer with nothing owed", 0, rsp.raw_value);
				end else begin
					want = owed_values.pop_front();
					if (rsp.raw_value !== want.raw_value) begin
						report_mismatch("raw_value", want.raw_value, rsp.raw_value);
					end
					if (rsp.deviate !== want.deviate) begin
						report_mismatch("deviate", want.deviate, rsp.deviate);
					end
					n_checked++;
				end
			end
			if (req_valid && !req_stall) begin
				lehmer_draw(req, want);
				owed_values.push_back(want);
				n_accepted++;
			end
		end
	end

	// Driver. It moves on after a transfer or when idle, and works in bursts
	// of random length separated by random gaps. Some gaps are zero so that
	// back-to-back stretches occur; long ones land inside seeding runs.
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				req_valid <= 1'b0;
			end else if (draw_requests.size() != 0) begin
				req <= draw_requests.pop_front();
				req_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 12);
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4: gap_left = 0;
						5, 6, 7, 8, 9, 10, 11, 12, 13, 14: gap_left = $urandom_range(1, 5);
						15, 16, 17, 18: gap_left = $urandom_range(6, 40);
						default: gap_left = $urandom_range(41, 120);
					endcase
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver. The stall pattern is picked at random and held for a random stretch:
	// no stalls, coin flips, mostly stalled or rarely stalled.
	stall_mode_t stall_mode = STALL_NONE;
	int stall_mode_left = 0;

	always @(negedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(20, 300);
		end else begin
			stall_mode_left = stall_mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 5) != 0);
			default:     rsp_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results owed",
				cycle_count, owed_values.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The very first request is a draw on an unseeded
		// block, which must seed with 1 and ignore the seed field.
		queue_request(REQ_DRAW, LCG_MOD);
		queue_request(REQ_DRAW, 31'd0);
		// A zero seed and a seed equal to the modulus both seed with 1.
		queue_request(REQ_RESEED, 31'd0);
		queue_request(REQ_DRAW, 31'h5555_5555);
		queue_request(REQ_DRAW, 31'h2AAA_AAAA);
		queue_request(REQ_RESEED, LCG_MOD);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_RESEED, 31'd1);
		queue_request(REQ_RESEED, 31'h7FFF_FFFE);
		queue_request(REQ_DRAW, LCG_MOD);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_DRAW, 31'd1);
		queue_request(REQ_RESEED, 31'h5555_5555);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_RESEED, 31'h2AAA_AAAA);
		queue_request(REQ_DRAW, 31'h7FFF_FFFE);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_RESEED, 31'd16807);
		queue_request(REQ_DRAW, 31'd0);
		queue_request(REQ_DRAW, 31'd0);

		// Let the block drain completely before the random part.
		wait_for_idle();

		// Random part in four chunks, with one more full drain halfway.
		for (int chunk = 0; chunk < 4; chunk++) begin
			for (int i = 0; i < 100; i++) begin
				queue_random_request();
			end
			if (chunk == 1) begin
				wait_for_idle();
			end
		end

		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d reseeds, %0d seeding runs), %0d results checked",
			n_accepted, n_reseeds, n_seedings, n_checked);
		$display("%0d of %0d shuffle slots drawn from, deviate capped %0d times",
			$countones(slots_hit), TABLE_ENTRIES, cap_hits);
		if (mismatches == 0 && owed_values.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
